// ----- rtl/core/fksm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword stream matcher package
// Shared constants, character classes and lane types for the matcher.
// ----------------------------------------------------------------------------
package fksm_pkg;

   localparam int MAX_TAG_DEFAULT = 64;
   localparam int TAG_WORDS       = 8;
   localparam int TAG_WORD_W      = 64;
   localparam int CSR_IDX_W       = 4;
   localparam int ST_W            = 8;

   // Bit positions inside one attempt state entry.
   localparam int ST_MAIN0 = 0;
   localparam int ST_MAIN1 = 1;
   localparam int ST_SEP0  = 2;
   localparam int ST_SEP1  = 3;
   localparam int ST_ESCM0 = 4;
   localparam int ST_ESCM1 = 5;
   localparam int ST_ESCS  = 6;
   localparam int ST_DROP  = 7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPZ   = 8'h5A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef struct packed {
      logic       esc;      // byte is ESC
      logic       param;    // byte may continue an escape sequence
      logic       wide;     // top bit set, sets the double-byte flag
      logic [7:0] folded;   // byte as judged with the flag clear
      logic       sep_fold; // folded byte is a separator
      logic       sep_raw;  // raw byte is a separator
   } byte_info_type;

   typedef struct packed {
      logic [ST_W-1:0] own;  // contribution to this position's next state
      logic [1:0]      adv;  // fresh-read bits handed to the next position
      logic            hit;  // a match completed here
   } lane_out_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= CH_UPA && c <= CH_UPZ) begin
         return c | CASE_BIT;
      end
      return c;
   endfunction

   // Punctuation, space, newline and ESC.
   function automatic logic is_separator(input logic [7:0] c);
      return c inside {8'h60, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
                       8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h5F, 8'h3D, 8'h2B,
                       8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h5C, 8'h7C, 8'h3B, 8'h3A,
                       8'h27, 8'h22, 8'h2C, 8'h3C, 8'h2E, 8'h3E, 8'h2F, 8'h3F,
                       8'h0A, 8'h20, CH_ESC};
   endfunction

endpackage

// ----- rtl/core/fuzzy_keyword_stream_matcher.sv -----
// The result for a text byte appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless the response stalls; every keyword position
// after the first has a parallel lane, and one output register carries the result.
// Reset clears the keyword registers, all attempt states and the found flag.
// A beat marked last also clears all match state once its result is formed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword stream matcher
// Scans a text byte stream for a configured keyword with case folding,
// double-byte tracking and skipping of separators and escape sequences.
// ----------------------------------------------------------------------------
module fuzzy_keyword_stream_matcher #(
   parameter int MAX_TAG = fksm_pkg::MAX_TAG_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_text_byte,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic                                rsp_done_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fksm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fksm_pkg::TAG_WORD_W-1:0]     csr_data
);
   import fksm_pkg::*;

   localparam int Lanes = MAX_TAG - 1;

   logic [MAX_TAG-1:0][7:0]  key_byte;
   logic [MAX_TAG-1:0]       key_ends;
   byte_info_type            info;
   lane_out_type             lane_out [Lanes];
   logic [Lanes-1:0]         lane_hit;

   // Entry j holds the attempts waiting on keyword position j + 1.
   logic [Lanes-1:0][ST_W-1:0] states_ff, states_in;
   logic found_ff, found_in;
   logic lead_ff, lead_in;
   logic stopped_ff, stopped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff;
   logic rsp_done_ff;

   logic accept;
   logic start_live;
   logic start_eq;
   logic found_now;
   logic [ST_W-1:0] start_bits;

   assign csr_ready = 1'b1;

   fksm_keys #(
      .MaxTag (MAX_TAG)
   ) u_keys (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .key_byte (key_byte),
      .key_ends (key_ends)
   );

   fksm_decode u_decode (
      .text_byte (req_text_byte),
      .info      (info)
   );

   for (genvar j = 0; j < Lanes; j++) begin : g_lane
      fksm_lane u_lane (
         .state     (states_ff[j]),
         .text_byte (req_text_byte),
         .info      (info),
         .key_byte  (key_byte[j+1]),
         .key_ends  (key_ends[j+1]),
         .result    (lane_out[j])
      );
      assign lane_hit[j] = lane_out[j].hit;

      if (j == 0) begin : g_first
         assign states_in[j] = lane_out[j].own | start_bits;
      end else begin : g_rest
         assign states_in[j] = lane_out[j].own |
                               {{(ST_W-2){1'b0}}, lane_out[j-1].adv};
      end
   end

   // Attempts start only before a text NUL and not on a double-byte pair's second byte.
   always_comb begin
      start_live = ~stopped_ff & (req_text_byte != CH_NUL) & ~lead_ff;
      start_eq   = start_live & (key_byte[0] != CH_NUL) & (info.folded == key_byte[0]);
      start_bits = '0;
      start_bits[ST_MAIN0] = start_eq & ~key_ends[0];
      found_now  = found_ff | (start_eq & key_ends[0]) | (|lane_hit);

      stopped_in = stopped_ff | (req_text_byte == CH_NUL);
      if (stopped_ff || req_text_byte == CH_NUL) begin
         lead_in = lead_ff;
      end else if (lead_ff) begin
         lead_in = 1'b0;
      end else begin
         lead_in = info.wide;
      end

      found_in = found_now;
   end

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff    <= '0;
         found_ff     <= 1'b0;
         lead_ff      <= 1'b0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_last) begin
               states_ff  <= '0;
               found_ff   <= 1'b0;
               lead_ff    <= 1'b0;
               stopped_ff <= 1'b0;
            end else begin
               states_ff  <= states_in;
               found_ff   <= found_in;
               lead_ff    <= lead_in;
               stopped_ff <= stopped_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_found_ff <= found_now;
         rsp_done_ff  <= req_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

// ----- rtl/core/fksm_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text byte classifier
// Works out the folded form and character classes of one text byte, shared
// by all keyword positions.
// ----------------------------------------------------------------------------
module fksm_decode (
   input  logic [7:0]                  text_byte,
   output fksm_pkg::byte_info_type     info
);
   import fksm_pkg::*;

   logic [7:0] folded;

   always_comb begin
      folded        = text_byte[7] ? text_byte : fold_case(text_byte);
      info.esc      = (text_byte == CH_ESC);
      info.param    = (text_byte >= CH_ZERO && text_byte <= CH_NINE) ||
                      (text_byte == CH_SEMI) || (text_byte == CH_LBRK);
      info.wide     = text_byte[7];
      info.folded   = folded;
      info.sep_fold = is_separator(folded);
      info.sep_raw  = is_separator(text_byte);
   end

endmodule

// ----- rtl/core/fksm_keys.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword registers
// Holds the keyword bytes written through the register port and flags the
// positions after which the keyword ends.
// ----------------------------------------------------------------------------
module fksm_keys #(
   parameter int MaxTag = fksm_pkg::MAX_TAG_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [fksm_pkg::CSR_IDX_W-1:0]      wr_index,
   input  logic [fksm_pkg::TAG_WORD_W-1:0]     wr_data,
   output logic [MaxTag-1:0][7:0]              key_byte,
   output logic [MaxTag-1:0]                   key_ends
);
   import fksm_pkg::*;

   logic [MaxTag-1:0][7:0] key_ff;

   // Only the bytes the keyword can reach are kept; the rest of a word is dropped.
   for (genvar i = 0; i < MaxTag; i++) begin : g_byte
      localparam int Word = i / 8;
      localparam int Lsb  = (i % 8) * 8;

      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[i] <= 8'h00;
         end else if (wr_en && wr_index == CSR_IDX_W'(Word)) begin
            key_ff[i] <= wr_data[Lsb +: 8];
         end
      end

      if (i + 1 >= MaxTag) begin : g_tail
         assign key_ends[i] = 1'b1;
      end else begin : g_body
         assign key_ends[i] = (key_ff[i+1] == CH_NUL);
      end
   end

   assign key_byte = key_ff;

endmodule

// ----- rtl/core/fksm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword position lane
// Next-state logic for all attempts waiting on one keyword position.
// ----------------------------------------------------------------------------
module fksm_lane (
   input  logic [fksm_pkg::ST_W-1:0]     state,
   input  logic [7:0]                    text_byte,
   input  fksm_pkg::byte_info_type       info,
   input  logic [7:0]                    key_byte,
   input  logic                          key_ends,
   output fksm_pkg::lane_out_type        result
);
   import fksm_pkg::*;

   logic act0, act1;
   logic eq0, eq1;
   logic adv0, adv1, hit0, hit1;
   logic escs0, escs1, sep0, sep1;

   always_comb begin
      // Judging with the flag clear uses the folded byte; with it set, the raw byte.
      act0  = (state[ST_MAIN0] & ~info.esc) | state[ST_SEP0];
      act1  = (state[ST_MAIN1] & ~info.esc) | state[ST_SEP1];
      eq0   = (info.folded == key_byte);
      eq1   = (text_byte == key_byte);
      hit0  = act0 & eq0 & key_ends;
      hit1  = act1 & eq1 & key_ends;
      adv0  = act0 & eq0 & ~key_ends;
      adv1  = act1 & eq1 & ~key_ends;
      escs0 = act0 & ~eq0 & info.esc;
      escs1 = act1 & ~eq1 & info.esc;
      sep0  = act0 & ~eq0 & ~info.esc & info.sep_fold;
      sep1  = act1 & ~eq1 & ~info.esc & info.sep_raw;

      result.own           = '0;
      result.own[ST_SEP0]  = (sep0 & ~info.wide) | sep1 |
                             (state[ST_ESCM0] & ~info.param) | state[ST_DROP];
      result.own[ST_SEP1]  = (sep0 & info.wide) | (state[ST_ESCM1] & ~info.param);
      result.own[ST_ESCM0] = (state[ST_MAIN0] & info.esc) | (state[ST_ESCM0] & info.param);
      result.own[ST_ESCM1] = (state[ST_MAIN1] & info.esc) | (state[ST_ESCM1] & info.param);
      result.own[ST_ESCS]  = escs0 | escs1 | (state[ST_ESCS] & info.param);
      result.own[ST_DROP]  = state[ST_ESCS] & ~info.param;
      result.adv[0]        = (adv0 & ~info.wide) | adv1;
      result.adv[1]        = adv0 & info.wide;
      result.hit           = hit0 | hit1;
   end

endmodule
